FILE: hdl/qsu_pkg.sv
// Types, constants and decode functions shared by the quoted string unescaper.
`timescale 1ns / 1ps

package qsu_pkg;

   localparam int MAX_LENGTH = 65535;
   localparam logic [15:0] LEN_CAP = 16'((MAX_LENGTH < 65535) ? MAX_LENGTH : 65535);
   localparam int JOB_DEPTH = 4;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_CLOSED = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ESCAPE    = 3'd1;
   localparam logic [2:0] ERR_X_HEX     = 3'd2;
   localparam logic [2:0] ERR_U_HEX     = 3'd3;
   localparam logic [2:0] ERR_SURROGATE = 3'd4;
   localparam logic [2:0] ERR_UNTERM    = 3'd5;
   localparam logic [2:0] ERR_NO_QUOTE  = 3'd6;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [2:0]  err_code;
      logic [15:0] consumed_length;
      logic        run_last;
   } rsp_type;

   // all results caused by one input beat: up to three data bytes, then an optional tail
   typedef struct packed {
      logic [1:0]      n_bytes;
      logic [2:0][7:0] data;
      logic            has_tail;
      logic [1:0]      tail_kind;
      logic [2:0]      tail_err;
      logic [15:0]     tail_len;
   } job_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

   // {valid, value} for single-letter escapes
   function automatic logic [8:0] esc_map(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h61:     r = {1'b1, 8'd7};
         8'h62:     r = {1'b1, 8'd8};
         8'h66:     r = {1'b1, 8'd12};
         8'h6e:     r = {1'b1, 8'd10};
         8'h72:     r = {1'b1, 8'd13};
         8'h74:     r = {1'b1, 8'd9};
         8'h76:     r = {1'b1, 8'd11};
         8'h30:     r = {1'b1, 8'd0};
         CH_BSLASH: r = {1'b1, CH_BSLASH};
         CH_SQUOTE: r = {1'b1, CH_SQUOTE};
         CH_DQUOTE: r = {1'b1, CH_DQUOTE};
         default:   r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/qsu_front.sv
// Front end: per-beat parse state machine that turns each input byte into at most one job.
`timescale 1ns / 1ps

module qsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  qsu_pkg::req_type req,
   output logic             job_push,
   output qsu_pkg::job_type job
);

   qsu_pkg::phase_type phase_ff, phase_in;
   logic        dquote_ff, dquote_in;
   logic [15:0] hex_ff, hex_in;
   logic [2:0]  left_ff, left_in;
   logic        uni_ff, uni_in;
   logic [15:0] raw_ff, raw_in;

   logic [7:0]  b;
   logic        is_close, is_open;
   logic [4:0]  hd;
   logic [8:0]  em;
   logic [15:0] hex_new, raw_inc;
   logic        hex_done, cp_1, cp_2, cp_sur;

   assign b        = req.in_byte;
   assign is_close = b == (dquote_ff ? qsu_pkg::CH_DQUOTE : qsu_pkg::CH_SQUOTE);
   assign is_open  = (b == qsu_pkg::CH_DQUOTE) || (b == qsu_pkg::CH_SQUOTE);
   assign hd       = qsu_pkg::hex_digit(b);
   assign em       = qsu_pkg::esc_map(b);
   assign hex_new  = {hex_ff[11:0], hd[3:0]};
   assign hex_done = left_ff == 3'd1;
   assign cp_1     = hex_new[15:7] == 9'd0;
   assign cp_2     = hex_new[15:11] == 5'd0;
   assign cp_sur   = hex_new[15:11] == 5'b11011;
   assign raw_inc  = (phase_ff != qsu_pkg::PH_IDLE && raw_ff < qsu_pkg::LEN_CAP) ?
                     raw_ff + 16'd1 : raw_ff;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      dquote_in = dquote_ff;
      hex_in    = hex_ff;
      left_in   = left_ff;
      uni_in    = uni_ff;
      raw_in    = raw_inc;
      case (phase_ff)
         qsu_pkg::PH_BODY: begin
            if (is_close) phase_in = qsu_pkg::PH_IDLE;
            else if (b == qsu_pkg::CH_BSLASH) phase_in = qsu_pkg::PH_ESC;
         end
         qsu_pkg::PH_ESC: begin
            if (em[8]) begin
               phase_in = qsu_pkg::PH_BODY;
            end else if (b == qsu_pkg::CH_X || b == qsu_pkg::CH_U) begin
               phase_in = qsu_pkg::PH_HEX;
               hex_in   = 16'd0;
               uni_in   = b == qsu_pkg::CH_U;
               left_in  = (b == qsu_pkg::CH_U) ? 3'd4 : 3'd2;
            end else begin
               phase_in = qsu_pkg::PH_IDLE;
            end
         end
         qsu_pkg::PH_HEX: begin
            if (!hd[4]) begin
               phase_in = qsu_pkg::PH_IDLE;
            end else if (!hex_done) begin
               hex_in  = hex_new;
               left_in = left_ff - 3'd1;
            end else if (uni_ff && !cp_2 && cp_sur) begin
               phase_in = qsu_pkg::PH_IDLE;
            end else begin
               phase_in = qsu_pkg::PH_BODY;
               hex_in   = 16'd0;
               uni_in   = 1'b0;
               left_in  = 3'd0;
            end
         end
         default: begin
            if (is_open) begin
               phase_in  = qsu_pkg::PH_BODY;
               dquote_in = b == qsu_pkg::CH_DQUOTE;
               raw_in    = 16'd1;
            end
         end
      endcase
      if (req.in_last) phase_in = qsu_pkg::PH_IDLE;
      if (phase_in == qsu_pkg::PH_IDLE) begin
         hex_in  = 16'd0;
         left_in = 3'd0;
         uni_in  = 1'b0;
      end
   end

   // job contents
   always_comb begin
      job = '0;
      case (phase_ff)
         qsu_pkg::PH_BODY: begin
            if (is_close) begin
               job.has_tail  = 1'b1;
               job.tail_kind = qsu_pkg::KIND_CLOSED;
               job.tail_len  = raw_inc;
            end else if (b != qsu_pkg::CH_BSLASH) begin
               job.n_bytes = 2'd1;
               job.data[0] = b;
            end
         end
         qsu_pkg::PH_ESC: begin
            if (em[8]) begin
               job.n_bytes = 2'd1;
               job.data[0] = em[7:0];
            end else if (b != qsu_pkg::CH_X && b != qsu_pkg::CH_U) begin
               job.has_tail  = 1'b1;
               job.tail_kind = qsu_pkg::KIND_ERROR;
               job.tail_err  = qsu_pkg::ERR_ESCAPE;
            end
         end
         qsu_pkg::PH_HEX: begin
            if (!hd[4]) begin
               job.has_tail  = 1'b1;
               job.tail_kind = qsu_pkg::KIND_ERROR;
               job.tail_err  = uni_ff ? qsu_pkg::ERR_U_HEX : qsu_pkg::ERR_X_HEX;
            end else if (hex_done) begin
               if (!uni_ff || cp_1) begin
                  job.n_bytes = 2'd1;
                  job.data[0] = hex_new[7:0];
               end else if (cp_2) begin
                  job.n_bytes = 2'd2;
                  job.data[0] = {3'b110, hex_new[10:6]};
                  job.data[1] = {2'b10, hex_new[5:0]};
               end else if (cp_sur) begin
                  job.has_tail  = 1'b1;
                  job.tail_kind = qsu_pkg::KIND_ERROR;
                  job.tail_err  = qsu_pkg::ERR_SURROGATE;
               end else begin
                  job.n_bytes = 2'd3;
                  job.data[0] = {4'b1110, hex_new[15:12]};
                  job.data[1] = {2'b10, hex_new[11:6]};
                  job.data[2] = {2'b10, hex_new[5:0]};
               end
            end
         end
         default: begin
            if (!is_open) begin
               job.has_tail  = 1'b1;
               job.tail_kind = qsu_pkg::KIND_ERROR;
               job.tail_err  = qsu_pkg::ERR_NO_QUOTE;
            end
         end
      endcase
      // a tail always leaves the parser idle, so the buffer-end error never collides with it
      if (req.in_last && !job.has_tail && phase_ff != qsu_pkg::PH_IDLE &&
          !(phase_ff == qsu_pkg::PH_BODY && is_close)) begin
         job.has_tail  = 1'b1;
         job.tail_kind = qsu_pkg::KIND_ERROR;
         job.tail_err  = qsu_pkg::ERR_UNTERM;
      end else if (req.in_last && !job.has_tail && phase_ff != qsu_pkg::PH_BODY &&
                   phase_ff != qsu_pkg::PH_ESC && phase_ff != qsu_pkg::PH_HEX && is_open) begin
         job.has_tail  = 1'b1;
         job.tail_kind = qsu_pkg::KIND_ERROR;
         job.tail_err  = qsu_pkg::ERR_UNTERM;
      end
   end

   assign job_push = accept && (job.n_bytes != 2'd0 || job.has_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= qsu_pkg::PH_IDLE;
         dquote_ff <= 1'b0;
         hex_ff    <= 16'd0;
         left_ff   <= 3'd0;
         uni_ff    <= 1'b0;
         raw_ff    <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         dquote_ff <= dquote_in;
         hex_ff    <= hex_in;
         left_ff   <= left_in;
         uni_ff    <= uni_in;
         raw_ff    <= raw_in;
      end
   end

endmodule

FILE: hdl/qsu_job_fifo.sv
// Small register queue of jobs between the parser and the result sequencer.
`timescale 1ns / 1ps

module qsu_job_fifo #(
   parameter int DEPTH = qsu_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  qsu_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output qsu_pkg::job_type head,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qsu_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop) rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

FILE: hdl/qsu_back.sv
// Back end: splits each job into result beats and holds them in the output register.
`timescale 1ns / 1ps

module qsu_back (
   input  logic             clock,
   input  logic             reset,
   input  qsu_pkg::job_type job,
   input  logic             job_empty,
   output logic             job_pop,
   output logic             empty,
   input  logic             pop,
   output qsu_pkg::rsp_type rsp
);

   logic [1:0]       idx_ff, idx_in;
   logic             vld_ff, vld_in;
   qsu_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0]       total;
   logic             is_last, load;

   assign total   = {1'b0, job.n_bytes} + {2'b0, job.has_tail};
   assign is_last = ({1'b0, idx_ff} + 3'd1) == total;
   assign load    = !job_empty && (!vld_ff || pop);
   assign job_pop = load && is_last;
   assign empty   = !vld_ff;
   assign rsp     = rsp_ff;

   always_comb begin
      rsp_in = '0;
      if (idx_ff < job.n_bytes) begin
         rsp_in.out_kind = qsu_pkg::KIND_BYTE;
         rsp_in.out_byte = job.data[idx_ff];
      end else begin
         rsp_in.out_kind        = job.tail_kind;
         rsp_in.err_code        = job.tail_err;
         rsp_in.consumed_length = job.tail_len;
      end
      rsp_in.run_last = is_last;
      idx_in = idx_ff;
      vld_in = vld_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
         vld_in = 1'b1;
      end else if (pop) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

endmodule

FILE: hdl/quoted_string_unescaper.sv
// Top level of the quoted string unescaper.
// Takes one raw byte of a quoted literal per beat and returns its decoded bytes,
// a close beat with the consumed length, or an error beat; run_last marks the final
// result of each input byte that yields results. The parser takes one byte per cycle
// as long as the job queue (JOB_DEPTH entries) has room; a byte yields up to four
// results (a 3-byte UTF-8 escape at buffer end), so the sustained rate is one result
// per cycle while pop is held, set by the single result register. An accepted byte's
// job is written into the job queue, then loaded into the result register.
`timescale 1ns / 1ps

module quoted_string_unescaper #(
   parameter int JOB_DEPTH = qsu_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  qsu_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output qsu_pkg::rsp_type rsp_data
);

   logic             job_push, job_pop, job_empty;
   qsu_pkg::job_type job_in, job_head;

   qsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (push && !full),
      .req      (req_data),
      .job_push (job_push),
      .job      (job_in)
   );

   qsu_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   qsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_head),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp_data)
   );

endmodule
